// File: sv/box_blur_edge_average_unit_defines.svh
// assertion macros for the box blur edge average unit
// no dependencies; taken in by the top level with an include
`ifndef BOX_BLUR_EDGE_AVERAGE_UNIT_DEFINES_SVH
`define BOX_BLUR_EDGE_AVERAGE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// property that must hold at every clock edge outside reset
`define BBEA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// condition that must hold in the cycle after the trigger
`define BBEA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BBEA_ASSERT(lbl, clk, rst, prop, msg)
`define BBEA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// File: sv/bbea_pkg.sv
// shared constants, beat types and helpers for the box blur edge average unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bbea_pkg;

  // default sizes
  localparam int DEF_WINDOW    = 5;
  localparam int DEF_MAX_WIDTH = 2048;
  localparam int MAX_HEIGHT    = 4096;

  // field and register widths
  localparam int PIX_W     = 8;
  localparam int PIX_MAX   = 255;
  localparam int RGB_W     = 3 * PIX_W;
  localparam int FW_BITS   = 12;
  localparam int FH_BITS   = 13;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int ROW_W     = $clog2(MAX_HEIGHT + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // register values after reset
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  // item kinds
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [PIX_W-1:0] in_red;
    logic [PIX_W-1:0] in_green;
    logic [PIX_W-1:0] in_blue;
  } in_beat_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_blue;
    logic             frame_end;
  } out_beat_t;

  // zero height acts as one row, oversize is cut to the maximum
  function automatic logic [ROW_W-1:0] clamp_height(input logic [FH_BITS-1:0] h);
    logic [ROW_W-1:0] r;
    if (h == '0) begin
      r = ROW_W'(1);
    end else if (h > FH_BITS'(MAX_HEIGHT)) begin
      r = ROW_W'(MAX_HEIGHT);
    end else begin
      r = ROW_W'(h);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/bbea_row_store.sv
// ring of recent frame rows, one write port and one read port, registered read data
// uses bbea_pkg for the pixel width
`timescale 1ns / 1ps
`default_nettype none

module bbea_row_store #(
  parameter int AW = 14
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [bbea_pkg::RGB_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [bbea_pkg::RGB_W-1:0] rd_data
);

  logic [bbea_pkg::RGB_W-1:0] mem [0:(2**AW)-1];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, read data registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: sv/bbea_div.sv
// bit-serial restoring divider, three channels sharing one divisor
// no package dependencies
`timescale 1ns / 1ps
`default_nettype none

module bbea_div #(
  parameter int SB = 13,
  parameter int NB = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [SB-1:0] num_r,
  input  logic [SB-1:0] num_g,
  input  logic [SB-1:0] num_b,
  input  logic [NB-1:0] den,
  output logic          done,
  output logic [SB-1:0] quo_r,
  output logic [SB-1:0] quo_g,
  output logic [SB-1:0] quo_b
);

  localparam int STEP_W = $clog2(SB);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [NB-1:0]     den_q;
  logic [2:0][SB-1:0] quo;
  logic [2:0][NB-1:0] rem;
  logic [2:0][SB-1:0] quo_next;
  logic [2:0][NB-1:0] rem_next;

  // one quotient bit per channel each cycle while busy
  always_comb begin
    logic [NB:0] shifted;
    for (int ch = 0; ch < 3; ch++) begin
      shifted = {rem[ch], quo[ch][SB-1]};
      if (shifted >= {1'b0, den_q}) begin
        rem_next[ch] = NB'(shifted - {1'b0, den_q});
        quo_next[ch] = {quo[ch][SB-2:0], 1'b1};
      end else begin
        rem_next[ch] = NB'(shifted);
        quo_next[ch] = {quo[ch][SB-2:0], 1'b0};
      end
    end
  end

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(SB - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // operand and partial result registers
  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= {num_b, num_g, num_r};
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quo_r = quo[0];
  assign quo_g = quo[1];
  assign quo_b = quo[2];

endmodule

`default_nettype wire

// File: sv/box_blur_edge_average_unit.sv
// box blur edge average unit: each pixel becomes the truncated mean of its in-frame window
// an item that releases a result starts one row store read per window tap, then a
// bit-serial divide, SB being the width of the window sum; no new item is taken until
// that result is loaded into the output register
// reset (rst, synchronous): positions cleared, width 640, height 480, row store not cleared
// depends on bbea_pkg, bbea_row_store, bbea_div and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "box_blur_edge_average_unit_defines.svh"

module box_blur_edge_average_unit #(
  parameter int WINDOW    = bbea_pkg::DEF_WINDOW,
  parameter int MAX_WIDTH = bbea_pkg::DEF_MAX_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  bbea_pkg::in_beat_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output bbea_pkg::out_beat_t             out_data,
  input  logic                            cfg_write,
  input  logic [bbea_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bbea_pkg::CFG_W-1:0]      cfg_data
);

  localparam int HALF      = (WINDOW - 1) / 2;
  localparam int SPAN      = 2 * HALF + 1;
  // rows from the oldest window tap up to the newest written row
  localparam int RING_ROWS = 2 ** $clog2(3 * HALF + 1);
  localparam int RRB       = $clog2(RING_ROWS);
  localparam int CB        = $clog2(MAX_WIDTH);
  localparam int WB        = $clog2(MAX_WIDTH + 1);
  localparam int RB        = bbea_pkg::ROW_W;
  localparam int AW        = RRB + CB;
  localparam int DB        = $clog2(HALF * MAX_WIDTH + HALF + 3);
  localparam int WIB       = $clog2(SPAN);
  localparam int SB        = $clog2(SPAN * SPAN * bbea_pkg::PIX_MAX + 1);
  localparam int NB        = $clog2(SPAN * SPAN + 1);
  localparam int PW        = bbea_pkg::PIX_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  // zero width acts as one pixel, oversize is cut to the maximum
  function automatic logic [WB-1:0] clamp_w(input logic [bbea_pkg::FW_BITS-1:0] w);
    logic [WB-1:0] r;
    if (w == '0) begin
      r = WB'(1);
    end else if (32'(w) > 32'(MAX_WIDTH)) begin
      r = WB'(MAX_WIDTH);
    end else begin
      r = WB'(w);
    end
    return r;
  endfunction

  // pixels that must be in before the first result leaves
  function automatic logic [DB-1:0] delay_of(input logic [WB-1:0] w);
    return DB'(32'(HALF) * 32'(w) + 32'(HALF + 1));
  endfunction

  logic [2:0]     state;
  logic [WB-1:0]  eff_w;
  logic [RB-1:0]  eff_h;
  logic [DB-1:0]  delay;
  logic [WB-1:0]  in_col;
  logic [RB-1:0]  in_row;
  logic [WB-1:0]  out_col;
  logic [RB-1:0]  out_row;
  logic [DB-1:0]  diff;
  logic [WIB-1:0] wr;
  logic [WIB-1:0] wc;
  logic           rd_pending;
  logic [SB-1:0]  sum_r, sum_g, sum_b;
  logic [NB-1:0]  cnt;

  logic           in_done, take_pix, wrap, emit, in_fire;
  logic [WB-1:0]  col_inc, in_col_next;
  logic [RB-1:0]  in_row_next;
  logic [DB-1:0]  diff_next;
  logic [RB:0]    rsum, rrow;
  logic [WB:0]    csum, rcol;
  logic           row_ok, col_ok;
  logic [AW-1:0]  wr_addr, rd_addr;
  logic           mem_we, mem_re;
  logic [bbea_pkg::RGB_W-1:0] rd_data;
  logic           is_last, out_free, load_out;
  logic [WB-1:0]  out_col_inc;
  logic           div_start, div_done;
  logic [SB-1:0]  quo_r, quo_g, quo_b;

  // input side bookkeeping for the beat on offer
  always_comb begin
    in_done     = (in_row == eff_h);
    take_pix    = (in_data.req_type == bbea_pkg::REQ_PIXEL) && !in_done;
    col_inc     = in_col + WB'(1);
    wrap        = (col_inc == eff_w);
    in_col_next = in_col;
    in_row_next = in_row;
    if (take_pix) begin
      in_col_next = wrap ? '0 : col_inc;
      in_row_next = wrap ? in_row + RB'(1) : in_row;
    end
    diff_next = diff + DB'(take_pix);
    emit      = (diff_next != '0) && ((in_row_next == eff_h) || (diff_next >= delay));
  end

  assign in_ready = (state == S_IDLE) && !cfg_write && !rst;
  assign in_fire  = in_valid && in_ready;

  // window tap position and frame check
  always_comb begin
    rsum   = (RB+1)'(out_row) + (RB+1)'(wr);
    csum   = (WB+1)'(out_col) + (WB+1)'(wc);
    row_ok = (rsum >= (RB+1)'(HALF)) && (rsum < (RB+1)'(eff_h) + (RB+1)'(HALF));
    col_ok = (csum >= (WB+1)'(HALF)) && (csum < (WB+1)'(eff_w) + (WB+1)'(HALF));
    rrow   = rsum - (RB+1)'(HALF);
    rcol   = csum - (WB+1)'(HALF);
  end

  assign wr_addr = {in_row[RRB-1:0], in_col[CB-1:0]};
  assign rd_addr = {rrow[RRB-1:0], rcol[CB-1:0]};
  assign mem_we  = in_fire && take_pix;
  assign mem_re  = (state == S_READ);

  bbea_row_store #(
    .AW (AW)
  ) u_row_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (wr_addr),
    .wr_data ({in_data.in_blue, in_data.in_green, in_data.in_red}),
    .rd_en   (mem_re),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // window sums, cleared while idle
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      sum_r <= '0;
      sum_g <= '0;
      sum_b <= '0;
      cnt   <= '0;
    end else if (rd_pending) begin
      sum_r <= sum_r + SB'(rd_data[PW-1:0]);
      sum_g <= sum_g + SB'(rd_data[2*PW-1:PW]);
      sum_b <= sum_b + SB'(rd_data[3*PW-1:2*PW]);
      cnt   <= cnt + NB'(1);
    end
  end

  assign div_start = (state == S_START);

  bbea_div #(
    .SB (SB),
    .NB (NB)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num_r (sum_r),
    .num_g (sum_g),
    .num_b (sum_b),
    .den   (cnt),
    .done  (div_done),
    .quo_r (quo_r),
    .quo_g (quo_g),
    .quo_b (quo_b)
  );

  // output side
  assign is_last     = (out_row == eff_h - RB'(1)) && (out_col == eff_w - WB'(1));
  assign out_free    = !out_valid || out_ready;
  assign load_out    = (state == S_OUT) && out_free && !cfg_write;
  assign out_col_inc = out_col + WB'(1);

  // sequencer, positions and registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      eff_w      <= clamp_w(bbea_pkg::FW_BITS'(bbea_pkg::RESET_WIDTH));
      eff_h      <= bbea_pkg::clamp_height(bbea_pkg::FH_BITS'(bbea_pkg::RESET_HEIGHT));
      delay      <= delay_of(clamp_w(bbea_pkg::FW_BITS'(bbea_pkg::RESET_WIDTH)));
      in_col     <= '0;
      in_row     <= '0;
      out_col    <= '0;
      out_row    <= '0;
      diff       <= '0;
      wr         <= '0;
      wc         <= '0;
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= (state == S_READ) && row_ok && col_ok;
      if (cfg_write) begin
        // register write restarts the stream
        unique case (cfg_index)
          bbea_pkg::REG_FRAME_WIDTH: begin
            eff_w <= clamp_w(cfg_data[bbea_pkg::FW_BITS-1:0]);
            delay <= delay_of(clamp_w(cfg_data[bbea_pkg::FW_BITS-1:0]));
          end
          bbea_pkg::REG_FRAME_HEIGHT: begin
            eff_h <= bbea_pkg::clamp_height(cfg_data[bbea_pkg::FH_BITS-1:0]);
          end
        endcase
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
        diff    <= '0;
        state   <= S_IDLE;
      end else begin
        unique case (state)
          S_IDLE: begin
            if (in_fire) begin
              in_col <= in_col_next;
              in_row <= in_row_next;
              diff   <= diff_next;
              if (emit) begin
                wr    <= '0;
                wc    <= '0;
                state <= S_READ;
              end
            end
          end
          S_READ: begin
            // walk the window row by row
            if (wc == WIB'(SPAN - 1)) begin
              wc <= '0;
              if (wr == WIB'(SPAN - 1)) begin
                state <= S_ACC;
              end else begin
                wr <= wr + WIB'(1);
              end
            end else begin
              wc <= wc + WIB'(1);
            end
          end
          S_ACC: begin
            state <= S_START;
          end
          S_START: begin
            state <= S_DIV;
          end
          S_DIV: begin
            if (div_done) begin
              state <= S_OUT;
            end
          end
          S_OUT: begin
            if (out_free) begin
              if (is_last) begin
                in_col  <= '0;
                in_row  <= '0;
                out_col <= '0;
                out_row <= '0;
                diff    <= '0;
              end else begin
                out_col <= (out_col_inc == eff_w) ? '0 : out_col_inc;
                out_row <= (out_col_inc == eff_w) ? out_row + RB'(1) : out_row;
                diff    <= diff - DB'(1);
              end
              state <= S_IDLE;
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

  // result beat holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.out_red   <= quo_r[PW-1:0];
      out_data.out_green <= quo_g[PW-1:0];
      out_data.out_blue  <= quo_b[PW-1:0];
      out_data.frame_end <= is_last;
    end
  end

  // checks
  `BBEA_ASSERT(a_diff_bound, clk, rst, diff <= delay, "pending pixel count exceeds output delay")
  `BBEA_ASSERT(a_out_in_frame, clk, rst, (out_col < eff_w) && (out_row < eff_h), "output position outside frame")
  `BBEA_ASSERT_NEXT(a_frame_restart, clk, rst, load_out && is_last, (diff == '0) && (in_row == '0) && (out_row == '0), "positions not cleared after frame end")

endmodule

`default_nettype wire
